// ===== rtl/fabrik_chain_solver_unit_macros.svh =====
// Assertion helper macros for the chain solver block.
`ifndef FABRIK_CHAIN_SOLVER_UNIT_MACROS_SVH
`define FABRIK_CHAIN_SOLVER_UNIT_MACROS_SVH

// Concurrent check, reset aware.
`define FCS_ASSERT(lbl, clk_s, rst_n_s, prop) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) (prop)) \
		else $error("check failed");

`endif

// ===== rtl/fcs_pkg.sv =====
// ----------------------------------------------------------------------------
// fcs_pkg
// Shared types and constants for the chain solver.
// ----------------------------------------------------------------------------
`default_nettype none
package fcs_pkg;
	typedef struct packed {
		logic               action;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
	} fcs_in_t;

	typedef struct packed {
		logic signed [31:0] joint_x;
		logic signed [31:0] joint_y;
		logic signed [31:0] joint_z;
		logic               last_joint;
		logic               chain_empty;
		logic               truncated;
	} fcs_out_t;

	localparam logic ACT_LOAD  = 1'b0;
	localparam logic ACT_SOLVE = 1'b1;

	localparam logic REG_ITER = 1'b0;
	localparam logic REG_TOL  = 1'b1;

	localparam logic signed [33:0] DIFF_LIM = 34'sd2147483647;
endpackage
`default_nettype wire

// ===== rtl/fabrik_chain_solver_unit.sv =====
// FABRIK solver. A first joint load only records the root; each later load stalls the input
// while its segment length is found (3 squares, then a 32-step root).
// A solve sums the lengths and tests reach; a round is a tip test plus 2*(n-1) pulls
// (squares, root, three 66-step divides; a straight layout skips the squares and root, and
// a zero vector ends after one divide). Each joint is then emitted as one output word.
// Asynchronous active-low reset empties the chain and loads defaults (10 rounds, tol 66).
`default_nettype none
module fabrik_chain_solver_unit #(
	parameter int MAX_JOINTS = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire fcs_pkg::fcs_in_t  in_data,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output fcs_pkg::fcs_out_t      out_data,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic              cfg_index,
	input  wire logic [31:0]       cfg_data
);
	import fcs_pkg::*;

	localparam int IW = $clog2(MAX_JOINTS);
	localparam int CW = $clog2(MAX_JOINTS + 1);

	// sequencer states
	localparam logic [4:0] S_IDLE  = 5'd0;
	localparam logic [4:0] S_LDSQ  = 5'd1;
	localparam logic [4:0] S_LDRT  = 5'd2;
	localparam logic [4:0] S_TSUM  = 5'd3;
	localparam logic [4:0] S_RDIST = 5'd4;
	localparam logic [4:0] S_RDW   = 5'd5;
	localparam logic [4:0] S_STRD  = 5'd6;
	localparam logic [4:0] S_PRD   = 5'd7;
	localparam logic [4:0] S_PSQ   = 5'd8;
	localparam logic [4:0] S_PRT   = 5'd9;
	localparam logic [4:0] S_PDIV  = 5'd10;
	localparam logic [4:0] S_PDW   = 5'd11;
	localparam logic [4:0] S_PWR   = 5'd12;
	localparam logic [4:0] S_ITST  = 5'd13;
	localparam logic [4:0] S_TRD   = 5'd14;
	localparam logic [4:0] S_TSQ   = 5'd15;
	localparam logic [4:0] S_TRT   = 5'd16;
	localparam logic [4:0] S_EMRD  = 5'd17;
	localparam logic [4:0] S_EMIT  = 5'd18;
	localparam logic [4:0] S_SQ    = 5'd19;
	localparam logic [4:0] S_TDIF  = 5'd20;

	// modes of a pull
	localparam logic [1:0] M_STR = 2'd0;
	localparam logic [1:0] M_BWD = 2'd1;
	localparam logic [1:0] M_FWD = 2'd2;

	logic [4:0]  state_q;
	logic [4:0]  ret_q;
	logic [1:0]  mode_q;
	logic [7:0]  iter_lim_q;
	logic [30:0] tol_q;
	logic [7:0]  it_q;
	logic [CW-1:0] cnt_q;
	logic [IW-1:0] idx_q;
	logic        ovf_q;
	logic signed [31:0] root_x_q, root_y_q, root_z_q;
	logic signed [31:0] prev_x_q, prev_y_q, prev_z_q;
	logic signed [31:0] tgt_x_q, tgt_y_q, tgt_z_q;

	// joint and length memories
	logic signed [31:0] mem_x [MAX_JOINTS];
	logic signed [31:0] mem_y [MAX_JOINTS];
	logic signed [31:0] mem_z [MAX_JOINTS];
	logic [31:0]        mem_l [MAX_JOINTS];
	logic signed [31:0] rd_x_q, rd_y_q, rd_z_q;
	logic [31:0]        rd_l_q;
	logic [IW-1:0]      raddr;
	logic               we;
	logic [IW-1:0]      waddr;
	logic signed [31:0] wx, wy, wz;
	logic               lwe;
	logic [IW-1:0]      lwaddr;

	// vector work registers
	logic signed [31:0] src_x_q, src_y_q, src_z_q;
	logic signed [32:0] dx_q, dy_q, dz_q;
	logic [31:0]        len_q;
	logic [31:0]        seg_q;
	logic [65:0]        tot_q;
	logic [63:0]        acc_q;
	logic [1:0]         comp_q;
	logic signed [31:0] nx_q, ny_q, nz_q;

	// shared units
	logic        sq_start, sq_done;
	logic [31:0] sq_root;
	logic        dv_start, dv_done;
	logic [65:0] dv_q;
	logic [65:0] dv_num;
	logic [31:0] mul_a;
	logic [63:0] mul_p;
	logic signed [32:0] d_sel;

	fcs_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(sq_start), .radicand(acc_q),
		.done(sq_done), .root(sq_root)
	);
	fcs_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(dv_start), .dividend(dv_num),
		.divisor(len_q), .done(dv_done), .quotient(dv_q)
	);

	function automatic logic signed [32:0] sdiff(input logic signed [31:0] a,
			input logic signed [31:0] b);
		logic signed [33:0] d;
		d = 34'(a) - 34'(b);
		if (d > DIFF_LIM) return 33'sd2147483647;
		if (d < -DIFF_LIM) return -33'sd2147483647;
		return d[32:0];
	endfunction

	function automatic logic [31:0] magn(input logic signed [32:0] d);
		logic signed [32:0] m;
		m = (d < 0) ? -d : d;
		return m[31:0];
	endfunction

	function automatic logic signed [31:0] plc(input logic signed [31:0] p,
			input logic signed [32:0] d, input logic [65:0] q);
		logic [33:0]        qs;
		logic signed [35:0] r;
		qs = (q > 66'h1_FFFF_FFFF) ? 34'h1_FFFF_FFFF : q[33:0];
		r  = (d < 0) ? 36'(p) - $signed({2'b00, qs}) : 36'(p) + $signed({2'b00, qs});
		if (r > 36'sd2147483647) return 32'sh7FFF_FFFF;
		if (r < -36'sd2147483648) return 32'sh8000_0000;
		return r[31:0];
	endfunction

	assign d_sel = (comp_q == 2'd0) ? dx_q : (comp_q == 2'd1) ? dy_q : dz_q;
	assign mul_a = magn(d_sel);
	assign mul_p = mul_a * mul_a;
	assign dv_num = 66'(mul_a) * 66'(seg_q) + 66'(len_q >> 1);

	assign in_stall  = (state_q != S_IDLE);
	assign cfg_ready = (state_q == S_IDLE);

	// memory ports
	always_ff @(posedge clk) begin
		if (we) begin
			mem_x[waddr] <= wx;
			mem_y[waddr] <= wy;
			mem_z[waddr] <= wz;
		end
		if (lwe) mem_l[lwaddr] <= sq_root;
		rd_x_q <= mem_x[raddr];
		rd_y_q <= mem_y[raddr];
		rd_z_q <= mem_z[raddr];
		rd_l_q <= mem_l[raddr];
	end

	logic in_acc;
	assign in_acc = in_valid && !in_stall;
	logic [IW-1:0] last_idx;
	assign last_idx = IW'(cnt_q - CW'(1));
	logic tip_far;
	assign tip_far = !(sq_root < {1'b0, tol_q});

	// memory control
	always_comb begin
		raddr  = idx_q;
		we     = 1'b0;
		waddr  = idx_q;
		wx     = nx_q;
		wy     = ny_q;
		wz     = nz_q;
		lwe    = (state_q == S_LDRT) && sq_done;
		lwaddr = IW'(cnt_q - CW'(2));
		if (state_q == S_IDLE) begin
			if (in_acc && in_data.action == ACT_LOAD && cnt_q < CW'(MAX_JOINTS)) begin
				we    = 1'b1;
				waddr = IW'(cnt_q);
				wx    = in_data.pos_x;
				wy    = in_data.pos_y;
				wz    = in_data.pos_z;
			end
		end else if (state_q == S_TRT) begin
			// tip pinned to the target before the backward pass
			if (sq_done && tip_far) begin
				we    = 1'b1;
				waddr = last_idx;
				wx    = tgt_x_q;
				wy    = tgt_y_q;
				wz    = tgt_z_q;
			end
		end else if (state_q == S_PWR) begin
			we = 1'b1;
			// root pinned back at the end of the backward pass
			if (mode_q == M_BWD && idx_q == '0) begin
				wx = root_x_q;
				wy = root_y_q;
				wz = root_z_q;
			end
		end
	end

	assign sq_start = (state_q == S_SQ);
	assign dv_start = (state_q == S_PDIV);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			iter_lim_q <= 8'd10;
			tol_q      <= 31'd66;
			cnt_q      <= '0;
			ovf_q      <= 1'b0;
			root_x_q   <= '0;
			root_y_q   <= '0;
			root_z_q   <= '0;
			prev_x_q   <= '0;
			prev_y_q   <= '0;
			prev_z_q   <= '0;
			out_valid  <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (cfg_valid && cfg_ready) begin
						if (cfg_index == REG_ITER) iter_lim_q <= cfg_data[7:0];
						else tol_q <= cfg_data[30:0];
					end
					if (in_acc) begin
						if (in_data.action == ACT_LOAD) begin
							if (cnt_q >= CW'(MAX_JOINTS)) begin
								ovf_q <= 1'b1;
							end else begin
								cnt_q    <= cnt_q + CW'(1);
								prev_x_q <= in_data.pos_x;
								prev_y_q <= in_data.pos_y;
								prev_z_q <= in_data.pos_z;
								if (cnt_q == '0) begin
									root_x_q <= in_data.pos_x;
									root_y_q <= in_data.pos_y;
									root_z_q <= in_data.pos_z;
								end else begin
									dx_q    <= sdiff(prev_x_q, in_data.pos_x);
									dy_q    <= sdiff(prev_y_q, in_data.pos_y);
									dz_q    <= sdiff(prev_z_q, in_data.pos_z);
									acc_q   <= '0;
									comp_q  <= 2'd0;
									ret_q   <= S_LDRT;
									state_q <= S_LDSQ;
								end
							end
						end else begin
							tgt_x_q <= in_data.pos_x;
							tgt_y_q <= in_data.pos_y;
							tgt_z_q <= in_data.pos_z;
							idx_q   <= '0;
							it_q    <= '0;
							if (cnt_q < CW'(2)) begin
								state_q <= S_EMRD;
							end else begin
								tot_q   <= '0;
								state_q <= S_TSUM;
							end
						end
					end
				end
				// accumulate squares over the three components
				S_LDSQ, S_PSQ, S_TSQ: begin
					acc_q  <= acc_q + mul_p;
					comp_q <= comp_q + 2'd1;
					if (comp_q == 2'd2) state_q <= S_SQ;
				end
				S_SQ: state_q <= ret_q;
				S_LDRT: if (sq_done) state_q <= S_IDLE;
				// sum segment lengths; the memory read is registered
				S_TSUM: begin
					idx_q <= idx_q + IW'(1);
					if (idx_q != '0) tot_q <= tot_q + 66'(rd_l_q);
					if (idx_q == IW'(cnt_q - CW'(1))) begin
						dx_q    <= sdiff(tgt_x_q, root_x_q);
						dy_q    <= sdiff(tgt_y_q, root_y_q);
						dz_q    <= sdiff(tgt_z_q, root_z_q);
						acc_q   <= '0;
						comp_q  <= 2'd0;
						ret_q   <= S_RDW;
						state_q <= S_LDSQ;
					end
				end
				S_RDW: begin
					if (sq_done) begin
						len_q <= sq_root;
						if (66'(sq_root) > tot_q) begin
							mode_q  <= M_STR;
							src_x_q <= root_x_q;
							src_y_q <= root_y_q;
							src_z_q <= root_z_q;
							idx_q   <= IW'(1);
							state_q <= S_STRD;
						end else begin
							state_q <= S_ITST;
						end
					end
				end
				// segment length read: idx in the backward pass, idx-1 otherwise
				S_STRD: state_q <= S_PRD;
				S_PRD: begin
					if (mode_q == M_STR) begin
						comp_q  <= 2'd0;
						state_q <= S_PDIV;
					end else begin
						dx_q    <= sdiff(rd_x_q, src_x_q);
						dy_q    <= sdiff(rd_y_q, src_y_q);
						dz_q    <= sdiff(rd_z_q, src_z_q);
						acc_q   <= '0;
						comp_q  <= 2'd0;
						ret_q   <= S_PRT;
						state_q <= S_PSQ;
					end
				end
				S_PRT: begin
					if (sq_done) begin
						len_q   <= sq_root;
						comp_q  <= 2'd0;
						state_q <= S_PDIV;
					end
				end
				S_PDIV: state_q <= S_PDW;
				S_PDW: begin
					if (dv_done) begin
						if (len_q == '0) begin
							// zero vector: joint lands on its source
							nx_q    <= src_x_q;
							ny_q    <= src_y_q;
							nz_q    <= src_z_q;
							state_q <= S_PWR;
						end else begin
							unique case (comp_q)
								2'd0: nx_q <= plc(src_x_q, dx_q, dv_q);
								2'd1: ny_q <= plc(src_y_q, dy_q, dv_q);
								default: nz_q <= plc(src_z_q, dz_q, dv_q);
							endcase
							if (comp_q == 2'd2) begin
								state_q <= S_PWR;
							end else begin
								comp_q  <= comp_q + 2'd1;
								state_q <= S_PDIV;
							end
						end
					end
				end
				// write back joint, pick next pull
				S_PWR: begin
					if (mode_q == M_BWD) begin
						if (idx_q == '0) begin
							mode_q  <= M_FWD;
							src_x_q <= root_x_q;
							src_y_q <= root_y_q;
							src_z_q <= root_z_q;
							idx_q   <= IW'(1);
							state_q <= S_STRD;
						end else begin
							src_x_q <= nx_q;
							src_y_q <= ny_q;
							src_z_q <= nz_q;
							idx_q   <= idx_q - IW'(1);
							state_q <= S_STRD;
						end
					end else begin
						src_x_q <= nx_q;
						src_y_q <= ny_q;
						src_z_q <= nz_q;
						if (idx_q == last_idx) begin
							if (mode_q == M_STR) begin
								idx_q   <= '0;
								state_q <= S_EMRD;
							end else begin
								it_q    <= it_q + 8'd1;
								state_q <= S_ITST;
							end
						end else begin
							idx_q   <= idx_q + IW'(1);
							state_q <= S_STRD;
						end
					end
				end
				// round test: limit, then tip distance
				S_ITST: begin
					if (it_q >= iter_lim_q) begin
						idx_q   <= '0;
						state_q <= S_EMRD;
					end else begin
						idx_q   <= last_idx;
						state_q <= S_TRD;
					end
				end
				S_TRD: state_q <= S_TDIF;
				// tip read is back: set up its distance to the target
				S_TDIF: begin
					dx_q    <= sdiff(rd_x_q, tgt_x_q);
					dy_q    <= sdiff(rd_y_q, tgt_y_q);
					dz_q    <= sdiff(rd_z_q, tgt_z_q);
					acc_q   <= '0;
					comp_q  <= 2'd0;
					ret_q   <= S_TRT;
					state_q <= S_TSQ;
				end
				S_TRT: begin
					if (sq_done) begin
						if (!tip_far) begin
							idx_q   <= '0;
							state_q <= S_EMRD;
						end else begin
							mode_q  <= M_BWD;
							src_x_q <= tgt_x_q;
							src_y_q <= tgt_y_q;
							src_z_q <= tgt_z_q;
							idx_q   <= IW'(cnt_q - CW'(2));
							state_q <= S_STRD;
						end
					end
				end
				S_EMRD: state_q <= S_EMIT;
				S_EMIT: begin
					if (!out_valid) begin
						out_valid            <= 1'b1;
						out_data.chain_empty <= (cnt_q == '0);
						out_data.truncated   <= ovf_q;
						out_data.last_joint  <= (cnt_q == '0) || (idx_q == last_idx);
						out_data.joint_x     <= (cnt_q == '0) ? '0 : rd_x_q;
						out_data.joint_y     <= (cnt_q == '0) ? '0 : rd_y_q;
						out_data.joint_z     <= (cnt_q == '0) ? '0 : rd_z_q;
					end else if (!out_stall) begin
						out_valid <= 1'b0;
						if (out_data.last_joint) begin
							cnt_q    <= '0;
							ovf_q    <= 1'b0;
							root_x_q <= '0;
							root_y_q <= '0;
							root_z_q <= '0;
							state_q  <= S_IDLE;
						end else begin
							idx_q   <= idx_q + IW'(1);
							state_q <= S_EMRD;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// length for the divide: the segment of idx in the backward pass, of idx-1 otherwise
	logic [IW-1:0] seg_idx;
	assign seg_idx = (mode_q == M_BWD) ? idx_q : IW'(idx_q - IW'(1));

	always_ff @(posedge clk) begin
		if (state_q == S_STRD) seg_q <= mem_l[seg_idx];
	end

	`include "fabrik_chain_solver_unit_macros.svh"
	`FCS_ASSERT(a_no_in_busy, clk, arst_n, (state_q != S_IDLE) |-> in_stall)
	`FCS_ASSERT(a_out_only_emit, clk, arst_n, out_valid |-> (state_q == S_EMIT))
	`FCS_ASSERT(a_cnt_cap, clk, arst_n, cnt_q <= CW'(MAX_JOINTS))
endmodule
`default_nettype wire

// ===== rtl/fcs_sqrt.sv =====
// ----------------------------------------------------------------------------
// fcs_sqrt
// Bit-serial floor square root of a 64-bit value, two result bits per
// cycle pair.
// ----------------------------------------------------------------------------
`default_nettype none
module fcs_sqrt (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [63:0] radicand,
	output logic             done,
	output logic [31:0]      root
);
	logic [63:0] rem_q;
	logic [63:0] res_q;
	logic [63:0] bit_q;
	logic        busy_q;
	logic [64:0] trial;

	assign trial = {1'b0, res_q} + {1'b0, bit_q};

	// one digit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q) begin
				if (bit_q == 64'd1) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= radicand;
			res_q <= '0;
			bit_q <= 64'h4000_0000_0000_0000;
		end else if (busy_q) begin
			if ({1'b0, rem_q} >= trial) begin
				rem_q <= rem_q - trial[63:0];
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign root = res_q[31:0];
endmodule
`default_nettype wire

// ===== rtl/fcs_divider.sv =====
// ----------------------------------------------------------------------------
// fcs_divider
// Restoring divider, 66-bit dividend by 32-bit divisor, one quotient bit
// per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module fcs_divider (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [65:0] dividend,
	input  wire logic [31:0] divisor,
	output logic             done,
	output logic [65:0]      quotient
);
	logic [65:0] quo_q;
	logic [32:0] rem_q;
	logic [31:0] dsr_q;
	logic [6:0]  cnt_q;
	logic        busy_q;
	logic [33:0] shifted;
	logic        ge;

	assign shifted = {rem_q, quo_q[65]};
	assign ge      = shifted >= {2'b00, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 7'd66;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	// shift-subtract step
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[64:0], ge};
			rem_q <= ge ? 33'(shifted - {2'b00, dsr_q}) : shifted[32:0];
		end
	end

	assign quotient = quo_q;
endmodule
`default_nettype wire

// ===== bench/fabrik_chain_solver_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fabrik_chain_solver_unit_test
// Self-checking bench for the FABRIK chain solver. Joint loads and solve
// words go in with random gaps; every emitted joint word is compared against
// a bit-exact fixed-point solver model in this file or a directed row's word.
// ----------------------------------------------------------------------------
module fabrik_chain_solver_unit_test;
	import fcs_pkg::*;

	localparam int MAX_JOINTS = 16;
	localparam int WATCHDOG   = 2000000;
	localparam longint POS_HI = 64'sd2147483647;
	localparam longint POS_LO = -64'sd2147483648;

	typedef struct {
		fcs_in_t  word;
		bit       typed;
		fcs_out_t want;
	} dir_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	fcs_in_t     in_data = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	fcs_out_t    out_data;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_index = REG_ITER;
	logic [31:0] cfg_data = '0;

	// model state
	longint          jx [MAX_JOINTS];
	longint          jy [MAX_JOINTS];
	longint          jz [MAX_JOINTS];
	longint unsigned seg_len [MAX_JOINTS];
	int              n_loaded;
	bit              dropped;
	longint          base_x, base_y, base_z;
	longint unsigned round_cap;
	longint unsigned tip_tol;

	fcs_out_t pending_joints[$];
	fcs_out_t fresh_joints[$];
	dir_row_t rows[$];

	int  errors = 0;
	int  loads_sent = 0;
	int  solves_sent = 0;
	int  words_checked = 0;
	int  idle_cycles = 0;
	bit  quiet = 1'b0;
	bit  hold_req = 1'b0;
	bit  hold_done = 1'b0;
	int  hold_left = 0;
	int  burst_left = 0;

	fabrik_chain_solver_unit #(.MAX_JOINTS(MAX_JOINTS)) dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #4 clk = ~clk;

	// ---------------- fixed-point model ----------------
	function automatic longint clamp_diff(longint a, longint b);
		longint d = a - b;
		if (d > POS_HI) return POS_HI;
		if (d < -POS_HI) return -POS_HI;
		return d;
	endfunction

	function automatic longint unsigned absv(longint d);
		return (d < 0) ? longint'(-d) : d;
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned res = 0;
		longint unsigned b = 64'h4000_0000_0000_0000;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	function automatic longint unsigned vec_len(longint dx, longint dy, longint dz);
		return int_sqrt(absv(dx) * absv(dx) + absv(dy) * absv(dy) + absv(dz) * absv(dz));
	endfunction

	function automatic longint unsigned span(longint ax, longint ay, longint az,
			longint bx, longint by, longint bz);
		return vec_len(clamp_diff(ax, bx), clamp_diff(ay, by), clamp_diff(az, bz));
	endfunction

	// point at distance seg from p along d, with |d| = len
	function automatic longint step_toward(longint p, longint d, longint unsigned len,
			longint unsigned seg);
		longint unsigned q;
		longint r;
		if (len == 0) return p;
		q = (absv(d) * seg + len / 2) / len;
		if (q > 64'h1_FFFF_FFFF) q = 64'h1_FFFF_FFFF;
		r = (d < 0) ? p - longint'(q) : p + longint'(q);
		if (r > POS_HI) r = POS_HI;
		if (r < POS_LO) r = POS_LO;
		return r;
	endfunction

	function automatic void pull_joint(int dst, int src, longint unsigned seg);
		longint dx = clamp_diff(jx[dst], jx[src]);
		longint dy = clamp_diff(jy[dst], jy[src]);
		longint dz = clamp_diff(jz[dst], jz[src]);
		longint unsigned len = vec_len(dx, dy, dz);
		jx[dst] = step_toward(jx[src], dx, len, seg);
		jy[dst] = step_toward(jy[src], dy, len, seg);
		jz[dst] = step_toward(jz[src], dz, len, seg);
	endfunction

	function automatic void solve_chain(longint tx, longint ty, longint tz);
		int n = n_loaded;
		longint unsigned total = 0;
		longint dx, dy, dz;
		longint unsigned len;
		if (n < 2) return;
		for (int i = 0; i + 1 < n; i++) total += seg_len[i];
		// target out of reach: lay the chain straight toward it
		if (span(base_x, base_y, base_z, tx, ty, tz) > total) begin
			dx = clamp_diff(tx, base_x);
			dy = clamp_diff(ty, base_y);
			dz = clamp_diff(tz, base_z);
			len = vec_len(dx, dy, dz);
			for (int i = 1; i < n; i++) begin
				jx[i] = step_toward(jx[i-1], dx, len, seg_len[i-1]);
				jy[i] = step_toward(jy[i-1], dy, len, seg_len[i-1]);
				jz[i] = step_toward(jz[i-1], dz, len, seg_len[i-1]);
			end
			return;
		end
		for (longint unsigned it = 0; it < round_cap; it++) begin
			if (span(jx[n-1], jy[n-1], jz[n-1], tx, ty, tz) < tip_tol) break;
			jx[n-1] = tx; jy[n-1] = ty; jz[n-1] = tz;
			for (int i = n - 2; i >= 0; i--) pull_joint(i, i + 1, seg_len[i]);
			jx[0] = base_x; jy[0] = base_y; jz[0] = base_z;
			for (int i = 1; i < n; i++) pull_joint(i, i - 1, seg_len[i-1]);
		end
	endfunction

	// fills fresh_joints with the words this input word causes
	function automatic void predict_word(fcs_in_t w);
		longint px = longint'(w.pos_x);
		longint py = longint'(w.pos_y);
		longint pz = longint'(w.pos_z);
		int n = n_loaded;
		fcs_out_t e;
		fresh_joints.delete();
		if (w.action == ACT_LOAD) begin
			if (n >= MAX_JOINTS) begin
				dropped = 1'b1;
				return;
			end
			jx[n] = px; jy[n] = py; jz[n] = pz;
			if (n == 0) begin
				base_x = px; base_y = py; base_z = pz;
			end else begin
				seg_len[n-1] = span(jx[n-1], jy[n-1], jz[n-1], px, py, pz);
			end
			n_loaded = n + 1;
			return;
		end
		if (n == 0) begin
			e = '0;
			e.last_joint = 1'b1;
			e.chain_empty = 1'b1;
			e.truncated = dropped;
			fresh_joints.push_back(e);
		end else begin
			solve_chain(px, py, pz);
			for (int i = 0; i < n; i++) begin
				e.joint_x = jx[i][31:0];
				e.joint_y = jy[i][31:0];
				e.joint_z = jz[i][31:0];
				e.last_joint = (i == n - 1);
				e.chain_empty = 1'b0;
				e.truncated = dropped;
				fresh_joints.push_back(e);
			end
		end
		n_loaded = 0;
		dropped = 1'b0;
		base_x = 0; base_y = 0; base_z = 0;
	endfunction

	// ---------------- stimulus helpers ----------------
	function automatic fcs_in_t mk(logic act, int x, int y, int z);
		fcs_in_t w;
		w.action = act; w.pos_x = x; w.pos_y = y; w.pos_z = z;
		return w;
	endfunction

	function automatic void add_row(fcs_in_t w, bit typed, fcs_out_t want);
		dir_row_t r;
		r.word = w; r.typed = typed; r.want = want;
		rows.push_back(r);
	endfunction

	function automatic int pick_coord(bit wild, int near, int spread);
		if (!wild) return near + int'($urandom_range(0, 2 * spread)) - spread;
		case ($urandom_range(0, 3))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			default: return int'($urandom);
		endcase
	endfunction

	// drive one word; gaps come in bursts unless the run is in its quiet tail
	task automatic send_word(fcs_in_t w, bit typed = 1'b0,
			fcs_out_t want = '0);
		if (!quiet && $urandom_range(0, 7) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= w;
		do @(posedge clk); while (in_stall);
		predict_word(w);
		if (w.action == ACT_LOAD) loads_sent++;
		else solves_sent++;
		if (typed) pending_joints.push_back(want);
		else foreach (fresh_joints[i]) pending_joints.push_back(fresh_joints[i]);
	endtask

	// one register write, after which the channel is left idle
	task automatic write_reg(logic idx, logic [31:0] val);
		in_valid <= 1'b0;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == REG_ITER) round_cap = val[7:0];
		else tip_tol = val[30:0];
		@(posedge clk);
	endtask

	// block idle: all results back, plus room for a trailing segment root
	task automatic drain();
		in_valid <= 1'b0;
		while (pending_joints.size() != 0) @(posedge clk);
		repeat (64) @(posedge clk);
	endtask

	// chains of loads with random content, each closed by a solve
	task automatic run_chains(int n_items, int max_len, int quiet_from);
		int sent = 0;
		int len, pick, j;
		bit wild;
		int cx, cy, cz;
		int hx [MAX_JOINTS + 4];
		int hy [MAX_JOINTS + 4];
		int hz [MAX_JOINTS + 4];
		while (sent < n_items) begin
			pick = $urandom_range(0, 19);
			if (pick == 0) len = 0;
			else if (pick == 1) len = 1;
			else if (pick == 2 && max_len >= MAX_JOINTS)
				len = $urandom_range(MAX_JOINTS - 1, MAX_JOINTS + 3);
			else len = $urandom_range(2, (max_len < 5) ? max_len : 5);
			wild = ($urandom_range(0, 7) == 0);
			cx = pick_coord(1'b0, 0, 1 << 22);
			cy = pick_coord(1'b0, 0, 1 << 22);
			cz = pick_coord(1'b0, 0, 1 << 22);
			for (int i = 0; i < len; i++) begin
				cx = pick_coord(wild, cx, 1 << 18);
				cy = pick_coord(wild, cy, 1 << 18);
				cz = pick_coord(wild, cz, 1 << 18);
				hx[i] = cx; hy[i] = cy; hz[i] = cz;
				send_word(mk(ACT_LOAD, cx, cy, cz));
				sent++;
				if (sent >= quiet_from) quiet = 1'b1;
			end
			// target: mostly near some loaded joint, sometimes anywhere
			if (wild || len == 0 || $urandom_range(0, 3) == 0) begin
				cx = pick_coord(1'b1, 0, 0);
				cy = pick_coord(1'b1, 0, 0);
				cz = pick_coord(1'b1, 0, 0);
			end else begin
				j = $urandom_range(0, (len > MAX_JOINTS ? MAX_JOINTS : len) - 1);
				cx = pick_coord(1'b0, hx[j], 1 << 16);
				cy = pick_coord(1'b0, hy[j], 1 << 16);
				cz = pick_coord(1'b0, hz[j], 1 << 16);
			end
			send_word(mk(ACT_SOLVE, cx, cy, cz));
			sent++;
			if (sent >= quiet_from) quiet = 1'b1;
		end
	endtask

	// ---------------- receiver stall ----------------
	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else if (hold_req && !hold_done) begin
			// long hold-off so the block backs up into its input
			hold_done <= 1'b1;
			hold_left <= 3000;
			out_stall <= 1'b1;
		end else if (quiet) begin
			out_stall <= 1'b0;
		end else if (burst_left != 0) begin
			burst_left <= burst_left - 1;
			out_stall <= 1'b1;
		end else if ($urandom_range(0, 9) == 0) begin
			burst_left <= $urandom_range(0, 11);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// ---------------- result check ----------------
	always @(posedge clk) begin : check_words
		fcs_out_t head;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_joints.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected word %p", out_data);
			end else begin
				head = pending_joints.pop_front();
				words_checked++;
				if (out_data.joint_x !== head.joint_x || out_data.joint_y !== head.joint_y
						|| out_data.joint_z !== head.joint_z
						|| out_data.last_joint !== head.last_joint
						|| out_data.chain_empty !== head.chain_empty
						|| out_data.truncated !== head.truncated) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: expected %p, got %p", head, out_data);
				end
			end
		end
	end

	// ---------------- watchdog ----------------
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG) begin
			$display("timeout: no word moved for %0d cycles", idle_cycles);
			$display("fabrik_chain_solver_unit_test failed");
			$finish;
		end
	end

	// ---------------- main sequence ----------------
	initial begin
		fcs_out_t want;
		n_loaded = 0; dropped = 1'b0;
		base_x = 0; base_y = 0; base_z = 0;
		round_cap = 10; tip_tol = 66;

		// directed rows: edges of the fields and each special case
		want = '0; want.last_joint = 1'b1; want.chain_empty = 1'b1;
		add_row(mk(ACT_SOLVE, 0, 0, 0), 1'b1, want);
		add_row(mk(ACT_LOAD, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff), 1'b0, '0);
		want = '0; want.last_joint = 1'b1;
		want.joint_x = 32'sh7fffffff; want.joint_y = 32'sh7fffffff;
		want.joint_z = 32'sh7fffffff;
		add_row(mk(ACT_SOLVE, 32'sh80000000, 32'sh80000000, 32'sh80000000), 1'b1, want);
		// saturated differences
		add_row(mk(ACT_LOAD, 32'sh80000000, 32'sh7fffffff, 32'sh80000000), 1'b0, '0);
		add_row(mk(ACT_LOAD, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff), 1'b0, '0);
		add_row(mk(ACT_SOLVE, 0, 0, 0), 1'b0, '0);
		// zero-length segments: zero direction vectors
		add_row(mk(ACT_LOAD, 0, 0, 0), 1'b0, '0);
		add_row(mk(ACT_LOAD, 0, 0, 0), 1'b0, '0);
		add_row(mk(ACT_SOLVE, 1 << 16, 0, 0), 1'b0, '0);
		add_row(mk(ACT_LOAD, 0, 0, 0), 1'b0, '0);
		add_row(mk(ACT_LOAD, 0, 0, 0), 1'b0, '0);
		add_row(mk(ACT_SOLVE, 0, 0, 0), 1'b0, '0);
		// reachable target on a straight three-joint chain
		add_row(mk(ACT_LOAD, 0, 0, 0), 1'b0, '0);
		add_row(mk(ACT_LOAD, 1 << 16, 0, 0), 1'b0, '0);
		add_row(mk(ACT_LOAD, 2 << 16, 0, 0), 1'b0, '0);
		add_row(mk(ACT_SOLVE, 1 << 16, 1 << 16, 0), 1'b0, '0);
		add_row(mk(ACT_LOAD, -(3 << 16), -1, 5 << 16), 1'b0, '0);
		add_row(mk(ACT_LOAD, -(1 << 16), 2 << 16, -7), 1'b0, '0);
		add_row(mk(ACT_LOAD, 4 << 16, 0, 1), 1'b0, '0);
		add_row(mk(ACT_SOLVE, -(2 << 16), 1 << 16, 3 << 16), 1'b0, '0);
		add_row(mk(ACT_LOAD, 32'sh12345678, -32'sh1234, 0), 1'b0, '0);
		add_row(mk(ACT_SOLVE, 0, 0, 0), 1'b0, '0);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) send_word(rows[i].word, rows[i].typed, rows[i].want);
		drain();

		// no rounds at all; upper data bits must be ignored
		write_reg(REG_ITER, 32'hABCD_EF00);
		write_reg(REG_TOL, 32'd66);
		run_chains(60, MAX_JOINTS + 3, 1 << 30);
		drain();

		// many rounds, tolerance at its top: early exit, short chains only
		write_reg(REG_ITER, 32'd255);
		write_reg(REG_TOL, 32'hFFFF_FFFF);
		run_chains(60, 3, 1 << 30);
		drain();

		// zero tolerance: a two-joint chain runs every one of 255 rounds
		write_reg(REG_TOL, 32'd0);
		send_word(mk(ACT_LOAD, 0, 0, 0));
		send_word(mk(ACT_LOAD, 3 << 16, 1 << 16, -(2 << 16)));
		send_word(mk(ACT_SOLVE, 1 << 16, 2 << 16, 1 << 15));
		drain();

		// single round with back-pressure on the result side
		write_reg(REG_ITER, 32'd1);
		write_reg(REG_TOL, 32'd1000);
		hold_req = 1'b1;
		run_chains(60, MAX_JOINTS + 3, 1 << 30);
		drain();

		// default settings for the bulk, no idling at the tail
		write_reg(REG_ITER, 32'd10);
		write_reg(REG_TOL, 32'd66);
		run_chains(300, MAX_JOINTS + 3, 220);
		in_valid <= 1'b0;

		while (pending_joints.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (pending_joints.size() != 0) errors++;

		$display("covered %0d joint loads and %0d solves, %0d joint words checked",
			loads_sent, solves_sent, words_checked);
		$display("round limits 0/1/10/255, tolerances 0 to max, %0d mismatches", errors);
		if (errors == 0)
			$display("fabrik_chain_solver_unit_test passed");
		else
			$display("fabrik_chain_solver_unit_test failed");
		$finish;
	end
endmodule
